### design/smarsi_pkg.sv
package smarsi_pkg;

  // configuration port
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned REG_IDX_W = 2;

  // register indexes (byte address / 4)
  localparam logic [REG_IDX_W-1:0] REG_SHORT = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_RSI   = 2'd2;

  // period registers and day counter
  localparam int unsigned PERIOD_W   = 6;
  localparam int unsigned PERIOD_MAX = 63;
  localparam int unsigned DAY_W      = 7;
  localparam logic [DAY_W-1:0] DAY_SAT = 7'd64;

  localparam logic [PERIOD_W-1:0] SHORT_RST = 6'd6;
  localparam logic [PERIOD_W-1:0] LONG_RST  = 6'd15;
  localparam logic [PERIOD_W-1:0] RSI_RST   = 6'd5;

  // history read taps
  localparam int unsigned NUM_TAPS    = 5;
  localparam int unsigned TAP_SHORT   = 0;
  localparam int unsigned TAP_LONG    = 1;
  localparam int unsigned TAP_PREV    = 2;
  localparam int unsigned TAP_RSI_OUT = 3;
  localparam int unsigned TAP_RSI_PRE = 4;

  // trade signal codes
  localparam int unsigned SIG_W = 2;
  typedef logic signed [SIG_W-1:0] signal_t;
  localparam signal_t SIG_BUY  = 2'sd1;
  localparam signal_t SIG_HOLD = 2'sd0;
  localparam signal_t SIG_SELL = -2'sd1;

endpackage

### design/smarsi_if.sv
interface smarsi_in_if #(
  parameter int unsigned PRICE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [PRICE_WIDTH-1:0] price;
  logic                   start_series;

  modport source (output valid, output price, output start_series, input ready);
  modport sink   (input valid, input price, input start_series, output ready);
endinterface

interface smarsi_out_if;
  logic              valid;
  logic              ready;
  logic signed [1:0] signal;
  logic              indicators_ready;

  modport source (output valid, output signal, output indicators_ready, input ready);
  modport sink   (input valid, input signal, input indicators_ready, output ready);
endinterface

### design/sma_rsi_trade_signal.sv
// sma crossover trade signal filtered by an rsi band
// input channel: one closing price per item, start_series marks day 0 of a series.
// output channel: one result per input item, signal (1 buy, 0 hold, -1 sell) and
// indicators_ready, in input order.
// apb port: short window at 0x0, long window at 0x4, rsi window at 0x8 (6 bits each);
// write only while the block is idle. a zero period acts as one.
// throughput: one item per cycle while the output is taken; four register stages (history read, window sum
// update, products, compare) each advance when the next stage is free, so
// bubbles close up and an item is accepted while a finished result waits.
// the window sums update once per item in a single stage, which sets the rate.
// the price history lives in five copies of a small ram, one per read tap.
// reset: sums and day count clear, periods return to 6 / 15 / 5, pipeline empties.
// receiver stall: the output register holds, the stages behind it fill, then
// in ready drops until the output is taken.
module sma_rsi_trade_signal #(
  parameter int unsigned HISTORY_DEPTH = 64,
  parameter int unsigned PRICE_WIDTH   = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  smarsi_in_if.sink                in_if,
  smarsi_out_if.source             out_if,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [smarsi_pkg::ADDR_W-1:0] paddr,
  input  logic [smarsi_pkg::DATA_W-1:0] pwdata,
  output logic [smarsi_pkg::DATA_W-1:0] prdata,
  output logic                     pready
);
  import smarsi_pkg::*;

  localparam int unsigned AW      = $clog2(HISTORY_DEPTH);
  localparam int unsigned XW      = (AW + 1 > DAY_W) ? AW + 1 : DAY_W;
  localparam int unsigned SUM_W   = PRICE_WIDTH + 6;
  localparam int unsigned PROD_W  = SUM_W + PERIOD_W;
  localparam int unsigned MUL_W   = SUM_W + 3;
  localparam int unsigned SMA_MAX = (HISTORY_DEPTH - 1 > PERIOD_MAX) ? PERIOD_MAX
                                                                      : HISTORY_DEPTH - 1;
  localparam int unsigned RSI_MAX = (HISTORY_DEPTH - 2 > PERIOD_MAX) ? PERIOD_MAX
                                                                      : HISTORY_DEPTH - 2;

  // ring slot k items back from the write slot
  function automatic logic [AW-1:0] back_addr(input logic [AW-1:0] wr,
                                              input logic [DAY_W-1:0] k);
    logic [XW-1:0] wx;
    logic [XW-1:0] kx;
    logic [XW-1:0] diff;
    begin
      wx = XW'(wr);
      kx = XW'(k);
      if (wx >= kx) begin
        diff = wx - kx;
      end else begin
        diff = wx + XW'(HISTORY_DEPTH) - kx;
      end
      return diff[AW-1:0];
    end
  endfunction

  // zero acts as one, large values clamp to what the history holds
  function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] v,
                                                       input logic [PERIOD_W-1:0] hi);
    begin
      if (v == '0) begin
        return PERIOD_W'(1);
      end else if (v > hi) begin
        return hi;
      end else begin
        return v;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  logic [PERIOD_W-1:0]  short_per_q, long_per_q, rsi_per_q;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[REG_IDX_W+1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_per_q <= SHORT_RST;
      long_per_q  <= LONG_RST;
      rsi_per_q   <= RSI_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SHORT: short_per_q <= pwdata[PERIOD_W-1:0];
        REG_LONG:  long_per_q  <= pwdata[PERIOD_W-1:0];
        REG_RSI:   rsi_per_q   <= pwdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_SHORT: prdata = DATA_W'(short_per_q);
      REG_LONG:  prdata = DATA_W'(long_per_q);
      REG_RSI:   prdata = DATA_W'(rsi_per_q);
      default:   prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control
  logic va_q, vb_q, vc_q, out_valid_q;
  logic en_a, en_b, en_c, en_d;
  logic accept;

  assign en_d        = !out_valid_q || out_if.ready;
  assign en_c        = !vc_q || en_d;
  assign en_b        = !vb_q || en_c;
  assign en_a        = !va_q || en_b;
  assign in_if.ready = en_a;
  assign accept      = in_if.valid && en_a;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q        <= 1'b0;
      vb_q        <= 1'b0;
      vc_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en_a) va_q        <= in_if.valid;
      if (en_b) vb_q        <= va_q;
      if (en_c) vc_q        <= vb_q;
      if (en_d) out_valid_q <= vc_q;
    end
  end

  // ---------------------------------------------------------------------------
  // effective periods and day count at accept
  logic [PERIOD_W-1:0] s_eff, l_eff, r_eff;
  logic [DAY_W-1:0]    day_q, day_cur, day_nxt;
  logic [DAY_W-1:0]    r_plus1, warm_day;
  logic [AW-1:0]       wr_q;

  assign s_eff     = clamp_period(short_per_q, PERIOD_W'(SMA_MAX));
  assign l_eff     = clamp_period(long_per_q, PERIOD_W'(SMA_MAX));
  assign r_eff     = clamp_period(rsi_per_q, PERIOD_W'(RSI_MAX));
  assign r_plus1   = DAY_W'(r_eff) + DAY_W'(1);
  assign warm_day  = ((l_eff > r_eff) ? DAY_W'(l_eff) : DAY_W'(r_eff)) + DAY_W'(1);
  assign day_cur   = in_if.start_series ? '0 : day_q;
  assign day_nxt   = (day_cur >= DAY_SAT) ? DAY_SAT : day_cur + DAY_W'(1);

  // day counter and ring write slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      day_q <= '0;
      wr_q  <= '0;
    end else if (accept) begin
      day_q <= day_nxt;
      wr_q  <= (wr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wr_q + AW'(1);
    end
  end

  // ---------------------------------------------------------------------------
  // price history, one ram copy per read tap
  logic [AW-1:0]          rd_addr [NUM_TAPS];
  logic [PRICE_WIDTH-1:0] rd_data [NUM_TAPS];

  assign rd_addr[TAP_SHORT]   = back_addr(wr_q, DAY_W'(s_eff));
  assign rd_addr[TAP_LONG]    = back_addr(wr_q, DAY_W'(l_eff));
  assign rd_addr[TAP_PREV]    = back_addr(wr_q, DAY_W'(1));
  assign rd_addr[TAP_RSI_OUT] = back_addr(wr_q, DAY_W'(r_eff));
  assign rd_addr[TAP_RSI_PRE] = back_addr(wr_q, r_plus1);

  for (genvar t = 0; t < NUM_TAPS; t++) begin : g_hist
    smarsi_ram #(
      .WIDTH (PRICE_WIDTH),
      .DEPTH (HISTORY_DEPTH)
    ) u_hist (
      .clk_i   (clk_i),
      .we_i    (accept),
      .waddr_i (wr_q),
      .wdata_i (in_if.price),
      .re_i    (accept),
      .raddr_i (rd_addr[t]),
      .rdata_o (rd_data[t])
    );
  end

  // ---------------------------------------------------------------------------
  // stage a: item and window flags, history read in flight
  logic [PRICE_WIDTH-1:0] price_a_q;
  logic                   start_a_q, sub_s_a_q, sub_l_a_q, add_a_q, rem_a_q, rdy_a_q;
  logic [PERIOD_W-1:0]    s_a_q, l_a_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      price_a_q <= in_if.price;
      start_a_q <= in_if.start_series;
      sub_s_a_q <= day_cur >= DAY_W'(s_eff);
      sub_l_a_q <= day_cur >= DAY_W'(l_eff);
      add_a_q   <= day_cur >= DAY_W'(1);
      rem_a_q   <= day_cur >= r_plus1;
      rdy_a_q   <= day_cur >= warm_day;
      s_a_q     <= s_eff;
      l_a_q     <= l_eff;
    end
  end

  // ---------------------------------------------------------------------------
  // stage b: window sum update
  logic [SUM_W-1:0]       short_q, long_q, gain_q, loss_q;
  logic [SUM_W-1:0]       short_d, long_d, gain_d, loss_d;
  logic [SUM_W-1:0]       short_base, long_base, gain_base, loss_base;
  logic [SUM_W-1:0]       short_out, long_out;
  logic [PRICE_WIDTH-1:0] h_prev, h_rout, h_rpre, add_dif, rem_dif;
  logic                   add_up, rem_up;
  logic [SUM_W-1:0]       g_add, l_add, g_rem, l_rem;

  assign h_prev = rd_data[TAP_PREV];
  assign h_rout = rd_data[TAP_RSI_OUT];
  assign h_rpre = rd_data[TAP_RSI_PRE];

  always_comb begin
    short_base = start_a_q ? '0 : short_q;
    long_base  = start_a_q ? '0 : long_q;
    gain_base  = start_a_q ? '0 : gain_q;
    loss_base  = start_a_q ? '0 : loss_q;
    short_out  = sub_s_a_q ? SUM_W'(rd_data[TAP_SHORT]) : '0;
    long_out   = sub_l_a_q ? SUM_W'(rd_data[TAP_LONG]) : '0;
    // newest price change enters
    add_up     = price_a_q > h_prev;
    add_dif    = add_up ? price_a_q - h_prev : h_prev - price_a_q;
    // oldest price change leaves
    rem_up     = h_rout > h_rpre;
    rem_dif    = rem_up ? h_rout - h_rpre : h_rpre - h_rout;
    g_add      = (add_a_q && add_up) ? SUM_W'(add_dif) : '0;
    l_add      = (add_a_q && !add_up) ? SUM_W'(add_dif) : '0;
    g_rem      = (rem_a_q && rem_up) ? SUM_W'(rem_dif) : '0;
    l_rem      = (rem_a_q && !rem_up) ? SUM_W'(rem_dif) : '0;
    short_d    = short_base + SUM_W'(price_a_q) - short_out;
    long_d     = long_base + SUM_W'(price_a_q) - long_out;
    gain_d     = gain_base + g_add - g_rem;
    loss_d     = loss_base + l_add - l_rem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= '0;
      long_q  <= '0;
      gain_q  <= '0;
      loss_q  <= '0;
    end else if (en_b && va_q) begin
      short_q <= short_d;
      long_q  <= long_d;
      gain_q  <= gain_d;
      loss_q  <= loss_d;
    end
  end

  logic                rdy_b_q;
  logic [PERIOD_W-1:0] s_b_q, l_b_q;

  always_ff @(posedge clk_i) begin
    if (en_b) begin
      rdy_b_q <= rdy_a_q;
      s_b_q   <= s_a_q;
      l_b_q   <= l_a_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage c: cross products and scaled rsi sums
  logic [PROD_W-1:0] sma_a_q, sma_b_q;
  logic [MUL_W-1:0]  g7_q, g3_q, l7_q, l3_q;
  logic              lz_q, rdy_c_q;

  always_ff @(posedge clk_i) begin
    if (en_c) begin
      sma_a_q <= PROD_W'(short_q) * PROD_W'(l_b_q);
      sma_b_q <= PROD_W'(long_q) * PROD_W'(s_b_q);
      g7_q    <= {gain_q, 3'b000} - MUL_W'(gain_q);
      g3_q    <= MUL_W'({gain_q, 1'b0}) + MUL_W'(gain_q);
      l7_q    <= {loss_q, 3'b000} - MUL_W'(loss_q);
      l3_q    <= MUL_W'({loss_q, 1'b0}) + MUL_W'(loss_q);
      lz_q    <= loss_q == '0;
      rdy_c_q <= rdy_b_q;
    end
  end

  // ---------------------------------------------------------------------------
  // stage d: votes and combined signal into the output register
  signal_t sma_vote, rsi_vote, sig_d;
  signal_t signal_q;
  logic    ind_q;

  always_comb begin
    priority if (sma_a_q > sma_b_q) begin
      sma_vote = SIG_BUY;
    end else if (sma_a_q < sma_b_q) begin
      sma_vote = SIG_SELL;
    end else begin
      sma_vote = SIG_HOLD;
    end

    // zero loss counts as rsi 100
    priority if (lz_q) begin
      rsi_vote = SIG_SELL;
    end else if (g7_q < l3_q) begin
      rsi_vote = SIG_BUY;
    end else if (g3_q > l7_q) begin
      rsi_vote = SIG_SELL;
    end else begin
      rsi_vote = SIG_HOLD;
    end

    priority if (!rdy_c_q) begin
      sig_d = SIG_HOLD;
    end else if ((sma_vote == SIG_BUY && rsi_vote != SIG_SELL) ||
                 (rsi_vote == SIG_BUY && sma_vote != SIG_SELL)) begin
      sig_d = SIG_BUY;
    end else if ((sma_vote == SIG_SELL && rsi_vote != SIG_BUY) ||
                 (rsi_vote == SIG_SELL && sma_vote != SIG_BUY)) begin
      sig_d = SIG_SELL;
    end else begin
      sig_d = SIG_HOLD;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_d) begin
      signal_q <= sig_d;
      ind_q    <= rdy_c_q;
    end
  end

  assign out_if.valid            = out_valid_q;
  assign out_if.signal           = signal_q;
  assign out_if.indicators_ready = ind_q;

endmodule

### design/smarsi_ram.sv
module smarsi_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sim/trade_signal_sb_pkg.sv
package trade_signal_sb_pkg;
  import smarsi_pkg::*;

  // one predicted output item
  typedef struct packed {
    signal_t sig;
    logic    ready;
  } trade_call_t;

  class trade_signal_scoreboard;
    logic [31:0]   price_ring [64];
    logic [37:0]   short_sum, long_sum, gain_sum, loss_sum;
    logic [6:0]    day;
    logic [5:0]    slot;
    logic [5:0]    short_len, long_len, rsi_len;
    trade_call_t   calls_due [$];
    int            errors;

    function new();
      foreach (price_ring[i]) price_ring[i] = '0;
      short_sum = '0;
      long_sum  = '0;
      gain_sum  = '0;
      loss_sum  = '0;
      day       = '0;
      slot      = '0;
      short_len = SHORT_RST;
      long_len  = LONG_RST;
      rsi_len   = RSI_RST;
      errors    = 0;
    endfunction

    function void set_period(logic [REG_IDX_W-1:0] idx, logic [PERIOD_W-1:0] val);
      case (idx)
        REG_SHORT: short_len = val;
        REG_LONG:  long_len = val;
        REG_RSI:   rsi_len = val;
        default: ;
      endcase
    endfunction

    // zero acts as one, large values clip to what the ring can hold
    static function int unsigned eff_len(logic [5:0] v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : int'(v);
    endfunction

    // price k days back from the next write slot
    function logic [31:0] past(int unsigned k);
      logic [5:0] idx;
      idx = slot - 6'(k);
      return price_ring[idx];
    endfunction

    // add or drop one day-to-day change in the gain / loss sums
    function void move_change(logic [31:0] now, logic [31:0] prior, bit add);
      logic [37:0] step;
      if (now > prior) begin
        step = 38'(now) - 38'(prior);
        gain_sum = add ? gain_sum + step : gain_sum - step;
      end else begin
        step = 38'(prior) - 38'(now);
        loss_sum = add ? loss_sum + step : loss_sum - step;
      end
    endfunction

    // take in one accepted price and queue the trade call it produces
    function void note_price(logic [31:0] price, logic start);
      int unsigned s, l, r, d;
      logic [63:0] sma_a, sma_b;
      signal_t     sma_vote, rsi_vote;
      trade_call_t call;
      s = eff_len(short_len, 63);
      l = eff_len(long_len, 63);
      r = eff_len(rsi_len, 62);
      if (start) begin
        short_sum = '0;
        long_sum  = '0;
        gain_sum  = '0;
        loss_sum  = '0;
        day       = '0;
      end
      d = day;

      // window sums, terms leave only once they entered
      short_sum = short_sum + price;
      if (d >= s) short_sum = short_sum - past(s);
      long_sum = long_sum + price;
      if (d >= l) long_sum = long_sum - past(l);
      if (d >= 1) move_change(price, past(1), 1'b1);
      if (d >= r + 1) move_change(past(r), past(r + 1), 1'b0);

      price_ring[slot] = price;
      slot = slot + 6'd1;

      call.ready = (d >= ((l > r) ? l : r) + 1);
      call.sig   = SIG_HOLD;
      if (call.ready) begin
        sma_a = 64'(short_sum) * l;
        sma_b = 64'(long_sum) * s;
        if (sma_a > sma_b) sma_vote = SIG_BUY;
        else if (sma_a < sma_b) sma_vote = SIG_SELL;
        else sma_vote = SIG_HOLD;

        // rsi band 30 / 70 without division
        if (loss_sum == 0) rsi_vote = SIG_SELL;
        else if (64'(gain_sum) * 7 < 64'(loss_sum) * 3) rsi_vote = SIG_BUY;
        else if (64'(gain_sum) * 3 > 64'(loss_sum) * 7) rsi_vote = SIG_SELL;
        else rsi_vote = SIG_HOLD;

        if (sma_vote == SIG_BUY && rsi_vote != SIG_SELL) call.sig = SIG_BUY;
        else if (rsi_vote == SIG_BUY && sma_vote != SIG_SELL) call.sig = SIG_BUY;
        else if (sma_vote == SIG_SELL && rsi_vote != SIG_BUY) call.sig = SIG_SELL;
        else if (rsi_vote == SIG_SELL && sma_vote != SIG_BUY) call.sig = SIG_SELL;
      end

      day = (d >= DAY_SAT) ? DAY_SAT : 7'(d + 1);
      calls_due.push_back(call);
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("%0t mismatch: %s", $time, what);
    endtask

    // compare one output item with the oldest prediction
    task check_result(signal_t sig, logic ready);
      trade_call_t want;
      if (calls_due.size() == 0) begin
        report_mismatch("output item with no input item pending");
        return;
      end
      want = calls_due.pop_front();
      if (sig !== want.sig)
        report_mismatch($sformatf("signal %0d, predicted %0d", sig, want.sig));
      if (ready !== want.ready)
        report_mismatch($sformatf("indicators_ready %b, predicted %b", ready, want.ready));
    endtask

    function int pending();
      return calls_due.size();
    endfunction
  endclass

endpackage

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import smarsi_pkg::*;
  import trade_signal_sb_pkg::*;

  // directed prices: extremes, flat, rising and falling runs, restarts
  localparam logic [31:0] DIR_PRICE [25] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000,
    32'h7FFF_FFFF, 32'd1000, 32'd1000, 32'd1000, 32'd1000,
    32'd1000, 32'd1000, 32'd1100, 32'd1200, 32'd1300,
    32'd1290, 32'd1280, 32'd1270, 32'd5000, 32'd4900,
    32'd4800, 32'd4700, 32'd4600, 32'd4650, 32'd4700
  };
  localparam bit DIR_START [25] = '{
    0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0
  };

  // period settings per phase, the last phases pick theirs at random
  localparam int NUM_FIXED = 7;
  localparam int NUM_PHASES = 10;
  localparam logic [5:0] CFG_SHORT [NUM_FIXED] = '{6'd6, 6'd1, 6'd63, 6'd0, 6'd63, 6'd3, 6'd20};
  localparam logic [5:0] CFG_LONG  [NUM_FIXED] = '{6'd15, 6'd2, 6'd63, 6'd0, 6'd0, 6'd63, 6'd7};
  localparam logic [5:0] CFG_RSI   [NUM_FIXED] = '{6'd5, 6'd1, 6'd62, 6'd0, 6'd63, 6'd1, 6'd30};
  localparam longint PRICE_TOP = 64'hFFFF_FFFF;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  int unsigned results_seen;

  trade_signal_scoreboard sb = new();

  smarsi_in_if #(.PRICE_WIDTH(32)) in_if ();
  smarsi_out_if out_if ();

  sma_rsi_trade_signal #(
    .HISTORY_DEPTH(64),
    .PRICE_WIDTH  (32)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

  // watch both channels
  always @(posedge clk_i) begin
    if (in_if.valid === 1'b1 && in_if.ready === 1'b1)
      sb.note_price(in_if.price, in_if.start_series);
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      sb.check_result(out_if.signal, out_if.indicators_ready);
      results_seen++;
    end
  end

  // receiver: random stalls plus one long hold-off so the pipeline backs up
  initial begin : receiver
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready = 1'b0;
      end else if (!hold_done && results_seen >= 150 && in_if.valid === 1'b1) begin
        hold_done = 1'b1;
        hold_left = 64;
        out_if.ready = 1'b0;
      end else begin
        out_if.ready = ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  // one apb write, setup then access
  task automatic write_period(input logic [REG_IDX_W-1:0] idx, input logic [5:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = DATA_W'(val);
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    sb.set_period(idx, val);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // offer one price item, with random gaps ahead of it
  task automatic send_price(input logic [31:0] price, input bit start);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid        = 1'b1;
    in_if.price        = price;
    in_if.start_series = start;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  // wait until every predicted item has come out, then let the pipeline settle
  task automatic drain();
    in_if.valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // one price series as a random walk with a trend
  task automatic run_series(input int unsigned len, input bit with_start);
    longint p, drift, span;
    span  = longint'(1) << $urandom_range(0, 20);
    drift = longint'($urandom_range(0, 32'(span))) - span / 2;
    case ($urandom_range(0, 3))
      0:       p = $urandom_range(0, 255);
      1:       p = PRICE_TOP - $urandom_range(0, 255);
      default: p = $urandom;
    endcase
    for (int unsigned i = 0; i < len; i++) begin
      case ($urandom_range(0, 15))
        0:       p = $urandom;
        1:       ;
        default: p = p + drift + longint'($urandom_range(0, 32'(span))) - span / 2;
      endcase
      if (p < 0) p = 0;
      else if (p > PRICE_TOP) p = PRICE_TOP;
      send_price(32'(p), with_start && i == 0);
    end
  endtask

  initial begin : main
    int unsigned sent, len, warm, l_eff, r_eff;
    logic [5:0]  sv, lv, rv;
    bit          fresh;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_if.valid        = 1'b0;
    in_if.price        = '0;
    in_if.start_series = 1'b0;
    results_seen       = 0;
    src_idle_pct       = 26;
    snk_idle_pct       = 74;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: short windows so the signal is live after a few days
    write_period(REG_SHORT, 6'd2);
    write_period(REG_LONG, 6'd4);
    write_period(REG_RSI, 6'd3);
    for (int i = 0; i < 25; i++) send_price(DIR_PRICE[i], DIR_START[i]);
    drain();

    // random phases, each with its own period setting
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 4) begin
        src_idle_pct = 26;
        snk_idle_pct = 74;
      end else if (ph < 7) begin
        src_idle_pct = 74;
        snk_idle_pct = 26;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (ph < NUM_FIXED) begin
        sv = CFG_SHORT[ph];
        lv = CFG_LONG[ph];
        rv = CFG_RSI[ph];
      end else begin
        sv = 6'($urandom_range(0, 63));
        lv = 6'($urandom_range(0, 63));
        rv = 6'($urandom_range(0, 63));
      end
      write_period(REG_SHORT, sv);
      write_period(REG_LONG, lv);
      write_period(REG_RSI, rv);
      l_eff = (lv == 0) ? 1 : lv;
      r_eff = (rv == 0) ? 1 : ((rv > 62) ? 62 : rv);
      warm  = ((l_eff > r_eff) ? l_eff : r_eff) + 1;

      sent  = 0;
      fresh = 1'b1;
      while (sent < 25) begin
        // mostly full series past warm-up, some short broken ones
        if ($urandom_range(0, 7) == 0) len = $urandom_range(1, 5);
        else len = warm + $urandom_range(0, 6);
        // sometimes keep the old series going across the period change
        run_series(len, !(fresh && ph > 0 && $urandom_range(0, 2) == 0));
        sent += len;
        fresh = 1'b0;
      end
      drain();
    end

    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule

### sim.f
design/smarsi_pkg.sv
design/smarsi_if.sv
design/smarsi_ram.sv
design/sma_rsi_trade_signal.sv
sim/trade_signal_sb_pkg.sv
sim/tb.sv
